/* sv/cpp_pkg.sv */
// cpp_pkg: shared constants, register codes and pipeline structs for the projector
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package cpp_pkg;

    localparam int SCREEN_W  = 640;
    localparam int SCREEN_H  = 480;
    localparam int PIX_W     = 16;
    localparam int NUM_W     = 62;
    localparam int DEN_W     = 32;
    localparam int DIV_STEPS = NUM_W;
    localparam int ADDR_W    = 5;

    localparam logic signed [PIX_W-1:0] SCREEN_W_S = PIX_W'(SCREEN_W);
    localparam logic signed [PIX_W-1:0] SCREEN_H_S = PIX_W'(SCREEN_H);

    // projection values are held within +-2^47
    localparam logic signed [63:0] PROP_LIM = 64'sd140737488355328;

    typedef enum logic [2:0] {
        REG_POS_X,
        REG_POS_Y,
        REG_POS_Z,
        REG_TRIG_X,
        REG_TRIG_Y,
        REG_TRIG_Z,
        REG_PROJ_DIST,
        REG_ASPECT
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [31:0]        trig_x;
        logic [31:0]        trig_y;
        logic [31:0]        trig_z;
        logic [30:0]        proj_dist;
        logic [15:0]        aspect;
    } cfg_t;

    typedef struct packed {
        logic        clipped;
        logic        ahead;
        logic        neg_x;
        logic        neg_y;
        logic [63:0] depth_sq;
    } side_t;

endpackage

/* sv/cpp_regs.sv */
// cpp_regs: apb register file holding camera position, rotation trig and projection scales
// depends on cpp_pkg
`timescale 1ns / 1ps

module cpp_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cpp_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output cpp_pkg::cfg_t               cfg
);
    import cpp_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pos_x       <= '0;
            cfg_reg.pos_y       <= '0;
            cfg_reg.pos_z       <= '0;
            cfg_reg.trig_x      <= 32'h4000_0000;
            cfg_reg.trig_y      <= 32'h4000_0000;
            cfg_reg.trig_z      <= 32'h4000_0000;
            cfg_reg.proj_dist   <= 31'd65536;
            cfg_reg.aspect      <= 16'd16384;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_POS_X:       cfg_reg.pos_x       <= pwdata;
                REG_POS_Y:       cfg_reg.pos_y       <= pwdata;
                REG_POS_Z:       cfg_reg.pos_z       <= pwdata;
                REG_TRIG_X:      cfg_reg.trig_x      <= pwdata;
                REG_TRIG_Y:      cfg_reg.trig_y      <= pwdata;
                REG_TRIG_Z:      cfg_reg.trig_z      <= pwdata;
                REG_PROJ_DIST:   cfg_reg.proj_dist   <= pwdata[30:0];
                REG_ASPECT:      cfg_reg.aspect      <= pwdata[15:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_POS_X:       prdata = cfg_reg.pos_x;
            REG_POS_Y:       prdata = cfg_reg.pos_y;
            REG_POS_Z:       prdata = cfg_reg.pos_z;
            REG_TRIG_X:      prdata = cfg_reg.trig_x;
            REG_TRIG_Y:      prdata = cfg_reg.trig_y;
            REG_TRIG_Z:      prdata = cfg_reg.trig_z;
            REG_PROJ_DIST:   prdata = {1'b0, cfg_reg.proj_dist};
            REG_ASPECT:      prdata = {16'd0, cfg_reg.aspect};
        endcase
    end

endmodule

/* sv/cpp_xform.sv */
// cpp_xform: camera translate, three-axis rotation, depth tests, squares and numerators
// depends on cpp_pkg; feeds cpp_div
`timescale 1ns / 1ps

module cpp_xform (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic signed [31:0]         point_x,
    input  logic signed [31:0]         point_y,
    input  logic signed [31:0]         point_z,
    input  cpp_pkg::cfg_t              cfg,
    output logic                       out_valid,
    output logic [cpp_pkg::NUM_W-1:0]  num_x,
    output logic [cpp_pkg::NUM_W-1:0]  num_y,
    output logic [cpp_pkg::DEN_W-1:0]  den,
    output cpp_pkg::side_t             side
);
    import cpp_pkg::*;

    logic signed [15:0] c_x, s_x, c_y, s_y, c_z, s_z;

    logic [10:0] v_reg;

    // s0: translate
    logic signed [32:0] x0_reg, y0_reg, z0_reg;
    // s1/s2: about z
    logic signed [48:0] p1a_reg, p1b_reg, p1c_reg, p1d_reg;
    logic signed [32:0] z1_reg, z2_reg;
    logic signed [49:0] sum_a, sum_b;
    logic signed [35:0] a2_reg, b2_reg, b3_reg, b4_reg;
    // s3/s4: about y
    logic signed [51:0] p3a_reg, p3b_reg, p3c_reg, p3d_reg;
    logic signed [52:0] sum_zy, sum_dx;
    logic signed [38:0] zy4_reg, dx4_reg, dx5_reg;
    // s5/s6: about x
    logic signed [54:0] p5a_reg, p5b_reg, p5c_reg, p5d_reg;
    logic signed [55:0] sum_dy, sum_dz;
    logic signed [41:0] dx6_reg, dy6_reg, dz6_reg;
    // s7: saturate, magnitudes, flags
    logic signed [31:0] sx7_reg, sy7_reg, sz7_reg;
    logic [41:0]        mx7_reg, my7_reg, mz7_reg;
    logic signed [41:0] dx6_neg, dy6_neg, dz6_neg;
    logic               clip7_reg, front7_reg;
    // s8: products
    logic signed [63:0] nx8_reg, ny8_reg;
    logic [63:0]        qx8_reg, qy8_reg, qz8_reg;
    logic               ox8_reg, oy8_reg, oz8_reg;
    logic signed [31:0] sz8_reg;
    logic               clip8_reg, front8_reg;
    // s9: first sum, magnitudes
    logic [64:0]        sum_xy;
    logic [63:0]        sxy9_reg, sqz9_reg;
    logic [NUM_W-1:0]   nx9_reg, ny9_reg;
    logic [DEN_W-1:0]   d9_reg;
    logic               negx9_reg, negy9_reg, clip9_reg, front9_reg;
    logic signed [63:0] nx8_abs, ny8_abs;
    logic signed [31:0] sz8_abs;
    // s10: output
    logic [64:0]        sum_xyz;
    logic [NUM_W-1:0]   nx10_reg, ny10_reg;
    logic [DEN_W-1:0]   d10_reg;
    side_t              side10_reg;

    assign c_x = cfg.trig_x[31:16];
    assign s_x = cfg.trig_x[15:0];
    assign c_y = cfg.trig_y[31:16];
    assign s_y = cfg.trig_y[15:0];
    assign c_z = cfg.trig_z[31:16];
    assign s_z = cfg.trig_z[15:0];

    // round to q16.16: add half then floor shift
    always_comb
    begin
        sum_a  = 50'(p1a_reg) + 50'(p1b_reg) + 50'sd8192;
        sum_b  = 50'(p1c_reg) - 50'(p1d_reg) + 50'sd8192;
        sum_zy = 53'(p3a_reg) + 53'(p3b_reg) + 53'sd8192;
        sum_dx = 53'(p3c_reg) - 53'(p3d_reg) + 53'sd8192;
        sum_dy = 56'(p5a_reg) + 56'(p5b_reg) + 56'sd8192;
        sum_dz = 56'(p5c_reg) - 56'(p5d_reg) + 56'sd8192;
        dx6_neg = -dx6_reg;
        dy6_neg = -dy6_reg;
        dz6_neg = -dz6_reg;
        nx8_abs = nx8_reg[63] ? -nx8_reg : nx8_reg;
        ny8_abs = ny8_reg[63] ? -ny8_reg : ny8_reg;
        sz8_abs = sz8_reg[31] ? -sz8_reg : sz8_reg;
        sum_xy  = {1'b0, (ox8_reg ? 64'hFFFF_FFFF_FFFF_FFFF : qx8_reg)}
                + {1'b0, (oy8_reg ? 64'hFFFF_FFFF_FFFF_FFFF : qy8_reg)};
        sum_xyz = {1'b0, sxy9_reg} + {1'b0, sqz9_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[9:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        x0_reg <= 33'(point_x) - 33'(cfg.pos_x);
        y0_reg <= 33'(point_y) - 33'(cfg.pos_y);
        z0_reg <= 33'(point_z) - 33'(cfg.pos_z);

        p1a_reg <= s_z * y0_reg;
        p1b_reg <= c_z * x0_reg;
        p1c_reg <= c_z * y0_reg;
        p1d_reg <= s_z * x0_reg;
        z1_reg  <= z0_reg;

        a2_reg <= 36'(sum_a >>> 14);
        b2_reg <= 36'(sum_b >>> 14);
        z2_reg <= z1_reg;

        p3a_reg <= c_y * z2_reg;
        p3b_reg <= s_y * a2_reg;
        p3c_reg <= c_y * a2_reg;
        p3d_reg <= s_y * z2_reg;
        b3_reg  <= b2_reg;

        zy4_reg <= 39'(sum_zy >>> 14);
        dx4_reg <= 39'(sum_dx >>> 14);
        b4_reg  <= b3_reg;

        p5a_reg <= s_x * zy4_reg;
        p5b_reg <= c_x * b4_reg;
        p5c_reg <= c_x * zy4_reg;
        p5d_reg <= s_x * b4_reg;
        dx5_reg <= dx4_reg;

        dy6_reg <= 42'(sum_dy >>> 14);
        dz6_reg <= 42'(sum_dz >>> 14);
        dx6_reg <= 42'(dx5_reg);

        sx7_reg <= (dx6_reg > 42'sd2147483647) ? 32'sh7FFF_FFFF
                 : (dx6_reg < -42'sd2147483648) ? 32'sh8000_0000 : 32'(dx6_reg);
        sy7_reg <= (dy6_reg > 42'sd2147483647) ? 32'sh7FFF_FFFF
                 : (dy6_reg < -42'sd2147483648) ? 32'sh8000_0000 : 32'(dy6_reg);
        sz7_reg <= (dz6_reg > 42'sd2147483647) ? 32'sh7FFF_FFFF
                 : (dz6_reg < -42'sd2147483648) ? 32'sh8000_0000 : 32'(dz6_reg);
        mx7_reg <= dx6_reg[41] ? dx6_neg : dx6_reg;
        my7_reg <= dy6_reg[41] ? dy6_neg : dy6_reg;
        mz7_reg <= dz6_reg[41] ? dz6_neg : dz6_reg;
        clip7_reg  <= (dz6_reg == '0);
        front7_reg <= (dz6_reg > $signed({11'd0, cfg.proj_dist}));

        nx8_reg <= $signed({1'b0, cfg.proj_dist}) * sx7_reg;
        ny8_reg <= $signed({1'b0, cfg.proj_dist}) * sy7_reg;
        qx8_reg <= mx7_reg[31:0] * mx7_reg[31:0];
        qy8_reg <= my7_reg[31:0] * my7_reg[31:0];
        qz8_reg <= mz7_reg[31:0] * mz7_reg[31:0];
        ox8_reg <= |mx7_reg[41:32];
        oy8_reg <= |my7_reg[41:32];
        oz8_reg <= |mz7_reg[41:32];
        sz8_reg <= sz7_reg;
        clip8_reg  <= clip7_reg;
        front8_reg <= front7_reg;

        sxy9_reg  <= sum_xy[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_xy[63:0];
        sqz9_reg  <= oz8_reg ? 64'hFFFF_FFFF_FFFF_FFFF : qz8_reg;
        nx9_reg   <= nx8_abs[NUM_W-1:0];
        ny9_reg   <= ny8_abs[NUM_W-1:0];
        d9_reg    <= sz8_abs;
        negx9_reg <= nx8_reg[63] ^ sz8_reg[31];
        negy9_reg <= ny8_reg[63] ^ sz8_reg[31];
        clip9_reg  <= clip8_reg;
        front9_reg <= front8_reg;

        side10_reg.depth_sq <= sum_xyz[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_xyz[63:0];
        side10_reg.clipped  <= clip9_reg;
        side10_reg.ahead    <= front9_reg;
        side10_reg.neg_x    <= negx9_reg;
        side10_reg.neg_y    <= negy9_reg;
        nx10_reg <= nx9_reg;
        ny10_reg <= ny9_reg;
        d10_reg  <= d9_reg;
    end

    assign out_valid = v_reg[10];
    assign num_x     = nx10_reg;
    assign num_y     = ny10_reg;
    assign den       = d10_reg;
    assign side      = side10_reg;

endmodule

/* sv/cpp_div.sv */
// cpp_div: pipelined restoring divider, one quotient bit per stage, x and y share the divisor
// depends on cpp_pkg; sits between cpp_xform and cpp_post
`timescale 1ns / 1ps

module cpp_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [cpp_pkg::NUM_W-1:0]  num_x,
    input  logic [cpp_pkg::NUM_W-1:0]  num_y,
    input  logic [cpp_pkg::DEN_W-1:0]  den,
    input  cpp_pkg::side_t             in_side,
    output logic                       out_valid,
    output logic [cpp_pkg::NUM_W-1:0]  quo_x,
    output logic [cpp_pkg::NUM_W-1:0]  quo_y,
    output cpp_pkg::side_t             out_side
);
    import cpp_pkg::*;

    logic [DIV_STEPS:0] v_reg;
    logic [NUM_W-1:0]   nx_reg [0:DIV_STEPS];
    logic [NUM_W-1:0]   ny_reg [0:DIV_STEPS];
    logic [DEN_W-1:0]   rx_reg [0:DIV_STEPS];
    logic [DEN_W-1:0]   ry_reg [0:DIV_STEPS];
    logic [DEN_W-1:0]   d_reg  [0:DIV_STEPS];
    side_t              s_reg  [0:DIV_STEPS];

    // numerator shifts out the top, quotient bits shift in at the bottom
    function automatic logic [DEN_W+NUM_W-1:0] div_step(
        input logic [DEN_W-1:0] rem,
        input logic [NUM_W-1:0] n,
        input logic [DEN_W-1:0] d
    );
        logic [DEN_W:0]   shifted;
        logic [DEN_W+1:0] trial;
        shifted = {rem, n[NUM_W-1]};
        trial   = {1'b0, shifted} - {2'b00, d};
        if (trial[DEN_W+1])
            div_step = {shifted[DEN_W-1:0], n[NUM_W-2:0], 1'b0};
        else
            div_step = {trial[DEN_W-1:0], n[NUM_W-2:0], 1'b1};
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[DIV_STEPS-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        nx_reg[0] <= num_x;
        ny_reg[0] <= num_y;
        rx_reg[0] <= '0;
        ry_reg[0] <= '0;
        d_reg[0]  <= den;
        s_reg[0]  <= in_side;
        for (int k = 1; k <= DIV_STEPS; k++)
        begin
            {rx_reg[k], nx_reg[k]} <= div_step(rx_reg[k-1], nx_reg[k-1], d_reg[k-1]);
            {ry_reg[k], ny_reg[k]} <= div_step(ry_reg[k-1], ny_reg[k-1], d_reg[k-1]);
            d_reg[k] <= d_reg[k-1];
            s_reg[k] <= s_reg[k-1];
        end
    end

    assign out_valid = v_reg[DIV_STEPS];
    assign quo_x     = nx_reg[DIV_STEPS];
    assign quo_y     = ny_reg[DIV_STEPS];
    assign out_side  = s_reg[DIV_STEPS];

endmodule

/* sv/cpp_post.sv */
// cpp_post: sign and clamp of the quotients, aspect scale, pixel mapping and result register
// depends on cpp_pkg; fed by cpp_div
`timescale 1ns / 1ps

module cpp_post (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [cpp_pkg::NUM_W-1:0]  quo_x,
    input  logic [cpp_pkg::NUM_W-1:0]  quo_y,
    input  cpp_pkg::side_t             in_side,
    input  logic [15:0]                aspect,
    output logic                       done,
    output logic signed [15:0]         pix_col,
    output logic signed [15:0]         pix_row,
    output logic                       ahead,
    output logic                       clipped,
    output logic [63:0]                depth_squared
);
    import cpp_pkg::*;

    logic [3:0]         v_reg;
    side_t              s1_reg, s2_reg, s3_reg, s4_reg;
    logic signed [63:0] qx_full, qy_full, qx_s, qy_s;
    logic signed [48:0] qx1_reg, qy1_reg, qx2_reg, qx3_reg, py3_reg;
    logic signed [65:0] pa2_reg, pa_tr;
    logic signed [49:0] ex, ey;
    logic signed [65:0] pxp4_reg, pyp4_reg, px_tr, py_tr;
    logic               done_reg, front_reg, clip_reg;
    logic signed [15:0] sx_reg, sy_reg;
    logic [63:0]        d2_reg;

    always_comb
    begin
        qx_full = $signed({2'b00, quo_x});
        qy_full = $signed({2'b00, quo_y});
        qx_s    = in_side.neg_x ? -qx_full : qx_full;
        qy_s    = in_side.neg_y ? -qy_full : qy_full;
        // truncate toward zero: bias negatives before the shift
        pa_tr   = (pa2_reg + (pa2_reg[65] ? 66'sd16383 : 66'sd0)) >>> 14;
        ex      = 50'(qx3_reg) + 50'sd65536;
        ey      = 50'(py3_reg) + 50'sd65536;
        px_tr   = (pxp4_reg + (pxp4_reg[65] ? 66'sd131071 : 66'sd0)) >>> 17;
        py_tr   = (pyp4_reg + (pyp4_reg[65] ? 66'sd131071 : 66'sd0)) >>> 17;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg    <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            v_reg    <= {v_reg[2:0], in_valid};
            done_reg <= v_reg[3];
        end
    end

    always_ff @(posedge clk)
    begin
        qx1_reg <= (qx_s > PROP_LIM) ? 49'(PROP_LIM)
                 : (qx_s < -PROP_LIM) ? 49'(-PROP_LIM) : 49'(qx_s);
        qy1_reg <= (qy_s > PROP_LIM) ? 49'(PROP_LIM)
                 : (qy_s < -PROP_LIM) ? 49'(-PROP_LIM) : 49'(qy_s);
        s1_reg  <= in_side;

        pa2_reg <= qy1_reg * $signed({1'b0, aspect});
        qx2_reg <= qx1_reg;
        s2_reg  <= s1_reg;

        py3_reg <= (pa_tr > 66'(PROP_LIM)) ? 49'(PROP_LIM)
                 : (pa_tr < -66'(PROP_LIM)) ? 49'(-PROP_LIM) : 49'(pa_tr);
        qx3_reg <= qx2_reg;
        s3_reg  <= s2_reg;

        pxp4_reg <= ex * SCREEN_W_S;
        pyp4_reg <= ey * SCREEN_H_S;
        s4_reg   <= s3_reg;

        if (s4_reg.clipped)
        begin
            sx_reg <= '0;
            sy_reg <= '0;
            d2_reg <= '0;
        end
        else
        begin
            sx_reg <= (px_tr > 66'sd32767) ? 16'sh7FFF
                    : (px_tr < -66'sd32768) ? 16'sh8000 : 16'(px_tr);
            sy_reg <= (py_tr > 66'sd32767) ? 16'sh7FFF
                    : (py_tr < -66'sd32768) ? 16'sh8000 : 16'(py_tr);
            d2_reg <= s4_reg.depth_sq;
        end
        front_reg <= s4_reg.ahead & ~s4_reg.clipped;
        clip_reg  <= s4_reg.clipped;
    end

    assign done          = done_reg;
    assign pix_col       = sx_reg;
    assign pix_row       = sy_reg;
    assign ahead         = front_reg;
    assign clipped       = clip_reg;
    assign depth_squared = d2_reg;

`ifndef SYNTH
    a_clip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && clipped |-> pix_col == 16'sd0 && pix_row == 16'sd0
                             && depth_squared == 64'd0 && !ahead)
        else $error("clipped beat carries nonzero fields");
    a_front_depth: assert property (@(posedge clk) disable iff (!rst_n)
        done && ahead |-> depth_squared != 64'd0)
        else $error("in-front beat with zero depth");
    a_front_noclip: assert property (@(posedge clk) disable iff (!rst_n)
        done && ahead |-> !clipped)
        else $error("beat both in front and clipped");
`endif

endmodule

/* sv/camera_perspective_projector.sv */
// camera_perspective_projector: top level, apb registers and the projection pipeline
// depends on cpp_pkg, cpp_regs, cpp_xform, cpp_div, cpp_post
`timescale 1ns / 1ps

// Projects one world point per clock: busy never rises, so a point may be started in
// every cycle. Each result beat rises on done once its point has passed the translate,
// three rotations and squares, the 62-step bit-per-stage divider that forms
// distance * x / z and distance * y / z, and the clamp, aspect scale and pixel mapping.
// The result is shown for one cycle only and cannot be held off. The user must see that
// registers are written over apb only while no point is in flight; the block itself
// does not enforce it.
module camera_perspective_projector (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [31:0]         point_x,
    input  logic signed [31:0]         point_y,
    input  logic signed [31:0]         point_z,
    output logic                       done,
    output logic signed [15:0]         pix_col,
    output logic signed [15:0]         pix_row,
    output logic                       ahead,
    output logic                       clipped,
    output logic [63:0]                depth_squared,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cpp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import cpp_pkg::*;

    cfg_t             cfg;
    logic             xf_valid, dv_valid;
    logic [NUM_W-1:0] xf_num_x, xf_num_y, dv_quo_x, dv_quo_y;
    logic [DEN_W-1:0] xf_den;
    side_t            xf_side, dv_side;

    assign busy = 1'b0;

    cpp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cpp_xform u_xform (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start & ~busy),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z),
        .cfg       (cfg),
        .out_valid (xf_valid),
        .num_x     (xf_num_x),
        .num_y     (xf_num_y),
        .den       (xf_den),
        .side      (xf_side)
    );

    cpp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (xf_valid),
        .num_x     (xf_num_x),
        .num_y     (xf_num_y),
        .den       (xf_den),
        .in_side   (xf_side),
        .out_valid (dv_valid),
        .quo_x     (dv_quo_x),
        .quo_y     (dv_quo_y),
        .out_side  (dv_side)
    );

    cpp_post u_post (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (dv_valid),
        .quo_x         (dv_quo_x),
        .quo_y         (dv_quo_y),
        .in_side       (dv_side),
        .aspect        (cfg.aspect),
        .done          (done),
        .pix_col       (pix_col),
        .pix_row       (pix_row),
        .ahead         (ahead),
        .clipped       (clipped),
        .depth_squared (depth_squared)
    );

endmodule
